@@ rtl/sao_pkg.sv @@
// sao_pkg: shared types, codes and constants for the slot allocator
// used by sao_bitmap, sao_mul and slot_allocator_with_offsets_unit
`timescale 1ns / 1ps

package sao_pkg;

   // pool size default and bitmap row geometry
   localparam int SLOTS_DEF = 64;
   localparam int ROW_BITS  = 16;
   localparam int ROW_SEL   = 4;

   // field widths
   localparam int FUNC_W    = 3;
   localparam int SLOT_IN_W = 7;
   localparam int SLOT_W    = 6;
   localparam int OFF_W     = 18;
   localparam int VBO_W     = 26;
   localparam int TRI_W     = 17;
   localparam int IPS_W     = 12;
   localparam int VPS_W     = 12;
   localparam int VB_W      = 8;
   localparam int CSR_W     = 12;
   localparam int CSR_A_W   = 2;
   localparam int REQ_W     = 16;
   localparam int RSP_W     = 112;

   // shared multiplier geometry and divide-by-three reciprocal
   localparam int MUL_W     = 24;
   localparam int PROD_W    = 2 * MUL_W;
   localparam logic [MUL_W-1:0] RECIP3 = 24'd5592405;

   // configuration reset values
   localparam logic [IPS_W-1:0] IPS_RST = 12'd6;
   localparam logic [VPS_W-1:0] VPS_RST = 12'd4;
   localparam logic [VB_W-1:0]  VB_RST  = 8'd32;

   // operation codes
   typedef enum logic [FUNC_W-1:0] {
      FN_RESERVE  = 3'd0,
      FN_FREE     = 3'd1,
      FN_FREE_ALL = 3'd2,
      FN_LOCK     = 3'd3,
      FN_UNLOCK   = 3'd4,
      FN_LOCATE   = 3'd5
   } func_type;

   // configuration register indexes
   typedef enum logic [CSR_A_W-1:0] {
      REG_IPS = 2'd0,
      REG_VPS = 2'd1,
      REG_VB  = 2'd2
   } reg_type;

   // bitmap control group
   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clr_all;
   } bm_ctrl_type;

endpackage

@@ rtl/sao_bitmap.sv @@
// sao_bitmap: used-slot bitmap stored as rows in a memory, with per-row valid bits
// depends on sao_pkg
`timescale 1ns / 1ps

module sao_bitmap #(
   parameter int SLOTS = sao_pkg::SLOTS_DEF,
   localparam int ROWS = (SLOTS + sao_pkg::ROW_BITS - 1) / sao_pkg::ROW_BITS,
   localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sao_pkg::bm_ctrl_type          ctrl,
   input  logic [RW-1:0]                 rd_row,
   input  logic [RW-1:0]                 wr_row,
   input  logic [sao_pkg::ROW_BITS-1:0]  wr_data,
   output logic [sao_pkg::ROW_BITS-1:0]  rd_data
);

   logic [sao_pkg::ROW_BITS-1:0] mem [ROWS];
   logic [ROWS-1:0]              row_vld_ff;
   logic [ROWS-1:0]              row_vld_in;
   logic [sao_pkg::ROW_BITS-1:0] rd_raw_ff;
   logic                         rd_vld_ff;
   logic [sao_pkg::ROW_BITS-1:0] rd_pad_ff;
   logic [sao_pkg::ROW_BITS-1:0] pad_in;

   // bits past the end of the pool always read as used
   always_comb begin
      for (int b = 0; b < sao_pkg::ROW_BITS; b++) begin
         pad_in[b] = ((int'(rd_row) * sao_pkg::ROW_BITS + b) >= SLOTS);
      end
   end

   // row valid bits: free-all drops them all at once
   always_comb begin
      row_vld_in = row_vld_ff;
      if (ctrl.clr_all) begin
         row_vld_in = '0;
      end else if (ctrl.wr_en) begin
         row_vld_in[wr_row] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff <= '0;
      end else begin
         row_vld_ff <= row_vld_in;
      end
   end

   // row memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[wr_row] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         rd_raw_ff <= mem[rd_row];
         rd_vld_ff <= row_vld_ff[rd_row];
         rd_pad_ff <= pad_in;
      end
   end

   // a row never written since free-all reads as all free, apart from the padding bits past the pool
   assign rd_data = (rd_vld_ff ? rd_raw_ff : '0) | rd_pad_ff;

endmodule

@@ rtl/sao_mul.sv @@
// sao_mul: shared unsigned multiplier with a registered product
// depends on sao_pkg
`timescale 1ns / 1ps

module sao_mul (
   input  logic                        clock,
   input  logic                        en,
   input  logic [sao_pkg::MUL_W-1:0]   a,
   input  logic [sao_pkg::MUL_W-1:0]   b,
   output logic [sao_pkg::PROD_W-1:0]  prod
);

   logic [sao_pkg::PROD_W-1:0] prod_ff;
   logic [sao_pkg::PROD_W-1:0] prod_in;

   // one product per cycle while en is high
   assign prod_in = a * b;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

@@ rtl/slot_allocator_with_offsets_unit.sv @@
// slot allocator: reserve scans the bitmap one 16-slot row per cycle (ROWS = ceil(SLOTS / 16)
// rows in all); all words then run seven steps through the one shared multiplier (draw
// counts, divide by three, offsets). one word at a time; the next word is taken while a
// result waits in the output register. synchronous reset clears bitmap valid bits,
// high-water count and lock
`timescale 1ns / 1ps

module slot_allocator_with_offsets_unit #(
   parameter int SLOTS = sao_pkg::SLOTS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // req_tdata: func [2:0], slot_in [9:3]
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [sao_pkg::REQ_W-1:0]      req_tdata,
   // rsp_tdata: ok [0], slot_out [6:1], index_offset [24:7],
   // vertex_byte_offset [50:25], vertex_offset [68:51], draw_enable [69],
   // draw_vertices [87:70], draw_triangles [104:88]
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [sao_pkg::RSP_W-1:0]      rsp_tdata,
   input  logic                           csr_we,
   input  logic [sao_pkg::CSR_A_W-1:0]    csr_addr,
   input  logic [sao_pkg::CSR_W-1:0]      csr_wdata
);

   localparam int ROWS = (SLOTS + sao_pkg::ROW_BITS - 1) / sao_pkg::ROW_BITS;
   localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int IW   = $clog2(ROWS + 1);
   localparam int HW_W = $clog2(SLOTS + 1);
   localparam int FS_W = RW + sao_pkg::ROW_SEL;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_SCAN = 5'b00010,
      S_FREE = 5'b00100,
      S_MUL  = 5'b01000,
      S_OUT  = 5'b10000
   } state_type;

   typedef enum logic [2:0] {
      ST_TRI   = 3'd0,
      ST_DIV   = 3'd1,
      ST_VTX   = 3'd2,
      ST_VOFF  = 3'd3,
      ST_VBYTE = 3'd4,
      ST_IOFF  = 3'd5,
      ST_DRAIN = 3'd6
   } step_type;

   // configuration
   logic [sao_pkg::IPS_W-1:0] ips_ff;
   logic [sao_pkg::VPS_W-1:0] vps_ff;
   logic [sao_pkg::VB_W-1:0]  vb_ff;

   // control state
   state_type state_ff, state_in;
   step_type  step_ff, step_in;
   logic [HW_W-1:0] hw_ff, hw_in;
   logic            locked_ff, locked_in;
   logic [IW-1:0]   iss_ff, iss_in;
   logic            pend_ff, pend_in;
   logic [RW-1:0]   chk_ff, chk_in;
   logic            rsp_tvalid_ff, rsp_tvalid_in;

   // item payload and results
   logic [sao_pkg::FUNC_W-1:0]    func_ff, func_in;
   logic [sao_pkg::SLOT_IN_W-1:0] slot_ff, slot_in;
   logic                          ok_ff, ok_in;
   logic [sao_pkg::SLOT_W-1:0]    sout_ff, sout_in;
   logic [sao_pkg::MUL_W-1:0]     x_ff, x_in;
   logic [sao_pkg::MUL_W-1:0]     qest_ff, qest_in;
   logic [sao_pkg::TRI_W-1:0]     dt_ff, dt_in;
   logic [sao_pkg::OFF_W-1:0]     dv_ff, dv_in;
   logic [sao_pkg::OFF_W-1:0]     vo_ff, vo_in;
   logic [sao_pkg::VBO_W-1:0]     vbo_ff, vbo_in;
   logic [sao_pkg::OFF_W-1:0]     io_ff, io_in;
   logic [sao_pkg::RSP_W-1:0]     rsp_data_ff, rsp_data_in;

   // datapath
   sao_pkg::bm_ctrl_type          bm_ctrl;
   logic [RW-1:0]                 bm_rd_row;
   logic [RW-1:0]                 bm_wr_row;
   logic [sao_pkg::ROW_BITS-1:0]  bm_wr_data;
   logic [sao_pkg::ROW_BITS-1:0]  bm_rd_data;
   logic                          mul_en;
   logic [sao_pkg::MUL_W-1:0]     mul_a;
   logic [sao_pkg::MUL_W-1:0]     mul_b;
   logic [sao_pkg::PROD_W-1:0]    prod;

   logic                          accept;
   logic                          free_ok;
   logic [RW-1:0]                 free_row;
   logic                          zero_any;
   logic [sao_pkg::ROW_SEL-1:0]   zbit;
   logic [FS_W-1:0]               found_slot;
   logic [sao_pkg::ROW_SEL-1:0]   fbit;
   logic                          rd_more;
   logic                          loc_valid;
   logic [sao_pkg::VBO_W-1:0]     q3;
   logic [sao_pkg::VBO_W-1:0]     rem3;
   logic [sao_pkg::MUL_W-1:0]     q_fix;
   logic                          draw_en;

   sao_bitmap #(.SLOTS(SLOTS)) u_bitmap (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (bm_ctrl),
      .rd_row  (bm_rd_row),
      .wr_row  (bm_wr_row),
      .wr_data (bm_wr_data),
      .rd_data (bm_rd_data)
   );

   sao_mul u_mul (
      .clock (clock),
      .en    (mul_en),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // free target: slot field of the incoming word in idle, held word otherwise
   assign free_ok  = !req_tdata[9] && (int'(req_tdata[8:3]) < SLOTS);
   assign free_row = (state_ff == S_IDLE) ? RW'(int'(req_tdata[8:3]) / sao_pkg::ROW_BITS)
                                          : RW'(int'(slot_ff[5:0]) / sao_pkg::ROW_BITS);
   assign fbit     = slot_ff[sao_pkg::ROW_SEL-1:0];

   // lowest free bit of the row just read
   always_comb begin
      zbit = '0;
      for (int b = sao_pkg::ROW_BITS - 1; b >= 0; b--) begin
         if (!bm_rd_data[b]) begin
            zbit = sao_pkg::ROW_SEL'(b);
         end
      end
   end

   assign zero_any   = ~&bm_rd_data;
   assign found_slot = {chk_ff, zbit};
   assign rd_more    = (int'(iss_ff) < ROWS);

   // exact divide by three: reciprocal estimate is low by at most one
   assign q3    = {1'b0, qest_ff, 1'b0} + {2'b00, qest_ff};
   assign rem3  = {2'b00, x_ff} - q3;
   assign q_fix = (rem3 >= sao_pkg::VBO_W'(3)) ? qest_ff + 1'b1 : qest_ff;

   assign loc_valid = (func_ff == sao_pkg::FN_LOCATE) && ok_ff;
   assign draw_en   = !locked_ff && (hw_ff != '0);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      hw_in         = hw_ff;
      locked_in     = locked_ff;
      iss_in        = iss_ff;
      pend_in       = pend_ff;
      chk_in        = chk_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      func_in       = func_ff;
      slot_in       = slot_ff;
      ok_in         = ok_ff;
      sout_in       = sout_ff;
      x_in          = x_ff;
      qest_in       = qest_ff;
      dt_in         = dt_ff;
      dv_in         = dv_ff;
      vo_in         = vo_ff;
      vbo_in        = vbo_ff;
      io_in         = io_ff;
      rsp_data_in   = rsp_data_ff;
      bm_ctrl       = '0;
      bm_rd_row     = free_row;
      bm_wr_row     = free_row;
      bm_wr_data    = bm_rd_data & ~(sao_pkg::ROW_BITS'(1) << fbit);
      mul_en        = 1'b0;
      mul_a         = '0;
      mul_b         = '0;

      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               func_in = req_tdata[2:0];
               slot_in = req_tdata[9:3];
               ok_in   = 1'b1;
               sout_in = '0;
               step_in = ST_TRI;
               state_in = S_MUL;
               case (req_tdata[2:0])
                  sao_pkg::FN_RESERVE: begin
                     iss_in   = '0;
                     pend_in  = 1'b0;
                     state_in = S_SCAN;
                  end
                  sao_pkg::FN_FREE: begin
                     if (free_ok) begin
                        bm_ctrl.rd_en = 1'b1;
                        state_in      = S_FREE;
                     end
                  end
                  sao_pkg::FN_FREE_ALL: bm_ctrl.clr_all = 1'b1;
                  sao_pkg::FN_LOCK:     locked_in = 1'b1;
                  sao_pkg::FN_UNLOCK:   locked_in = 1'b0;
                  sao_pkg::FN_LOCATE:   ok_in = !req_tdata[9] && locked_ff;
                  default: ;
               endcase
            end
         end
         S_SCAN: begin
            // issue the next row while checking the one read last cycle
            bm_rd_row     = iss_ff[RW-1:0];
            bm_ctrl.rd_en = rd_more;
            pend_in       = rd_more;
            chk_in        = iss_ff[RW-1:0];
            if (rd_more) begin
               iss_in = iss_ff + 1'b1;
            end
            if (pend_ff && zero_any) begin
               bm_ctrl.wr_en = 1'b1;
               bm_wr_row     = chk_ff;
               bm_wr_data    = bm_rd_data | (sao_pkg::ROW_BITS'(1) << zbit);
               ok_in         = 1'b1;
               sout_in       = sao_pkg::SLOT_W'(int'(found_slot));
               if (int'(found_slot) == int'(hw_ff)) begin
                  hw_in = hw_ff + 1'b1;
               end
               state_in = S_MUL;
            end else if (!rd_more && !pend_ff) begin
               ok_in    = 1'b0;
               state_in = S_MUL;
            end
         end
         S_FREE: begin
            bm_ctrl.wr_en = 1'b1;
            state_in      = S_MUL;
         end
         S_MUL: begin
            mul_en  = 1'b1;
            step_in = step_type'(step_ff + 1'b1);
            case (step_ff)
               ST_TRI: begin
                  mul_a = sao_pkg::MUL_W'(hw_ff);
                  mul_b = sao_pkg::MUL_W'(ips_ff);
               end
               ST_DIV: begin
                  x_in  = prod[sao_pkg::MUL_W-1:0];
                  mul_a = prod[sao_pkg::MUL_W-1:0];
                  mul_b = sao_pkg::RECIP3;
               end
               ST_VTX: begin
                  qest_in = prod[sao_pkg::PROD_W-1:sao_pkg::MUL_W];
                  mul_a   = sao_pkg::MUL_W'(hw_ff);
                  mul_b   = sao_pkg::MUL_W'(vps_ff);
               end
               ST_VOFF: begin
                  dv_in = prod[sao_pkg::OFF_W-1:0];
                  dt_in = q_fix[sao_pkg::TRI_W-1:0];
                  mul_a = sao_pkg::MUL_W'(slot_ff[5:0]);
                  mul_b = sao_pkg::MUL_W'(vps_ff);
               end
               ST_VBYTE: begin
                  vo_in = prod[sao_pkg::OFF_W-1:0];
                  mul_a = prod[sao_pkg::MUL_W-1:0];
                  mul_b = sao_pkg::MUL_W'(vb_ff);
               end
               ST_IOFF: begin
                  vbo_in = prod[sao_pkg::VBO_W-1:0];
                  mul_a  = sao_pkg::MUL_W'(slot_ff[5:0]);
                  mul_b  = sao_pkg::MUL_W'(ips_ff);
               end
               default: begin
                  io_in    = prod[sao_pkg::OFF_W-1:0];
                  step_in  = step_ff;
                  state_in = S_OUT;
               end
            endcase
         end
         S_OUT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_data_in   = {7'b0, dt_ff, dv_ff, draw_en,
                                (loc_valid ? vo_ff : '0),
                                (loc_valid ? vbo_ff : '0),
                                (loc_valid ? io_ff : '0),
                                sout_ff, ok_ff};
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         step_ff       <= ST_TRI;
         hw_ff         <= '0;
         locked_ff     <= 1'b0;
         iss_ff        <= '0;
         pend_ff       <= 1'b0;
         chk_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         hw_ff         <= hw_in;
         locked_ff     <= locked_in;
         iss_ff        <= iss_in;
         pend_ff       <= pend_in;
         chk_ff        <= chk_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      slot_ff     <= slot_in;
      ok_ff       <= ok_in;
      sout_ff     <= sout_in;
      x_ff        <= x_in;
      qest_ff     <= qest_in;
      dt_ff       <= dt_in;
      dv_ff       <= dv_in;
      vo_ff       <= vo_in;
      vbo_ff      <= vbo_in;
      io_ff       <= io_in;
      rsp_data_ff <= rsp_data_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ips_ff <= sao_pkg::IPS_RST;
         vps_ff <= sao_pkg::VPS_RST;
         vb_ff  <= sao_pkg::VB_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            sao_pkg::REG_IPS: ips_ff <= csr_wdata[sao_pkg::IPS_W-1:0];
            sao_pkg::REG_VPS: vps_ff <= csr_wdata[sao_pkg::VPS_W-1:0];
            sao_pkg::REG_VB:  vb_ff  <= csr_wdata[sao_pkg::VB_W-1:0];
            default: ;
         endcase
      end
   end

   // an accepted word always takes the sequencer out of idle in the next cycle
   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("word accepted but sequencer stayed idle");

   // high-water count stays within the pool
   a_hw_bound: assert property (@(posedge clock) disable iff (reset)
      int'(hw_ff) <= SLOTS)
      else $error("high-water count beyond pool size");

   // high-water count only ever moves up by one
   a_hw_step: assert property (@(posedge clock) disable iff (reset)
      (hw_in != hw_ff) |-> (hw_in == HW_W'(hw_ff + 1'b1)))
      else $error("high-water count jumped");

   // a granted slot lies inside the pool
   a_grant_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && pend_ff && zero_any) |-> (int'(found_slot) < SLOTS))
      else $error("reserve granted a slot outside the pool");

endmodule
